### design/svm_pkg.sv
// Shared types, constants and helpers for the stack VM instruction executor.
// No dependencies.
package svm_pkg;

   localparam int unsigned MEM_BYTES = 65536;
   localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
   localparam logic [31:0] MAX_INSTR = 32'd65536;

   localparam logic [1:0] MODE_EXEC  = 2'd0;
   localparam logic [1:0] MODE_HWR   = 2'd1;
   localparam logic [1:0] MODE_HRD   = 2'd2;

   localparam logic [1:0] CSR_CAP    = 2'd0;
   localparam logic [1:0] CSR_ICOUNT = 2'd1;
   localparam logic [1:0] CSR_SSTART = 2'd2;

   localparam logic [3:0] ST_OK      = 4'd0;
   localparam logic [3:0] ST_EXITED  = 4'd1;
   localparam logic [3:0] ST_NULL    = 4'd2;
   localparam logic [3:0] ST_ALIGN   = 4'd3;
   localparam logic [3:0] ST_ACCESS  = 4'd4;
   localparam logic [3:0] ST_CODE    = 4'd5;
   localparam logic [3:0] ST_NOTSUB  = 4'd6;
   localparam logic [3:0] ST_DIVZERO = 4'd7;
   localparam logic [3:0] ST_OVFL    = 4'd8;
   localparam logic [3:0] ST_ZONE    = 4'd9;
   localparam logic [3:0] ST_UNSUP   = 4'd10;

   localparam logic [5:0] OP_STORE1   = 6'd0;
   localparam logic [5:0] OP_STORE2   = 6'd1;
   localparam logic [5:0] OP_STORE4   = 6'd2;
   localparam logic [5:0] OP_LOAD1    = 6'd3;
   localparam logic [5:0] OP_LOAD2    = 6'd4;
   localparam logic [5:0] OP_LOAD4    = 6'd5;
   localparam logic [5:0] OP_SEX8     = 6'd6;
   localparam logic [5:0] OP_SEX16    = 6'd7;
   localparam logic [5:0] OP_ZHI24    = 6'd8;
   localparam logic [5:0] OP_ZHI16    = 6'd9;
   localparam logic [5:0] OP_NEGL     = 6'd10;
   localparam logic [5:0] OP_CALL     = 6'd11;
   localparam logic [5:0] OP_BSL      = 6'd12;
   localparam logic [5:0] OP_BSRI     = 6'd13;
   localparam logic [5:0] OP_BSRU     = 6'd14;
   localparam logic [5:0] OP_BNOT     = 6'd15;
   localparam logic [5:0] OP_BAND     = 6'd16;
   localparam logic [5:0] OP_BOR      = 6'd17;
   localparam logic [5:0] OP_BXOR     = 6'd18;
   localparam logic [5:0] OP_MULU     = 6'd19;
   localparam logic [5:0] OP_DIVU     = 6'd20;
   localparam logic [5:0] OP_MODU     = 6'd21;
   localparam logic [5:0] OP_ADDL     = 6'd22;
   localparam logic [5:0] OP_SUBL     = 6'd23;
   localparam logic [5:0] OP_MULL     = 6'd24;
   localparam logic [5:0] OP_DIVL     = 6'd25;
   localparam logic [5:0] OP_MODL     = 6'd26;
   localparam logic [5:0] OP_JUMP     = 6'd27;
   localparam logic [5:0] OP_DISCARD  = 6'd28;
   localparam logic [5:0] OP_SKIPNEXT = 6'd29;
   localparam logic [5:0] OP_ADDR_SPR = 6'd30;
   localparam logic [5:0] OP_ADDR_ARG = 6'd31;
   localparam logic [5:0] OP_BEGINSUB = 6'd32;
   localparam logic [5:0] OP_ENDSUB   = 6'd33;
   localparam logic [5:0] OP_COPY     = 6'd34;
   localparam logic [5:0] OP_BEQ      = 6'd35;
   localparam logic [5:0] OP_BNE      = 6'd36;
   localparam logic [5:0] OP_BGEU     = 6'd37;
   localparam logic [5:0] OP_BGEL     = 6'd38;
   localparam logic [5:0] OP_BGTU     = 6'd39;
   localparam logic [5:0] OP_BGTL     = 6'd40;
   localparam logic [5:0] OP_BLEU     = 6'd41;
   localparam logic [5:0] OP_BLEL     = 6'd42;
   localparam logic [5:0] OP_BLTU     = 6'd43;
   localparam logic [5:0] OP_BLTL     = 6'd44;
   localparam logic [5:0] OP_IMMED    = 6'd45;
   localparam logic [5:0] OP_STSPR4   = 6'd46;
   localparam logic [5:0] OP_DROP8    = 6'd47;
   localparam logic [5:0] OP_DROP16   = 6'd48;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  opcode;
      logic [31:0] argument;
      logic [15:0] stack_offset;
      logic [15:0] block_id;
      logic [15:0] instr_index;
      logic [15:0] host_address;
      logic [7:0]  host_data;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] next_index;
      logic [31:0] return_value;
      logic [7:0]  read_data;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic [5:0] op;
   } alu_req_type;

   function automatic logic [MEM_AW-1:0] mem_addr(input logic [31:0] a);
      return a[MEM_AW-1:0];
   endfunction

   function automatic logic [MEM_AW-1:0] stk_addr(input logic [16:0] sp,
                                                   input logic [31:0] off);
      logic [31:0] s;
      s = {15'd0, sp} + off;
      return s[MEM_AW-1:0];
   endfunction

endpackage

### design/svm_mem.sv
// Byte-wide single-port data memory holding stack and heap.
// Depends on svm_pkg.
module svm_mem import svm_pkg::*; (
   input  logic              clock,
   input  logic [MEM_AW-1:0] addr,
   input  logic              we,
   input  logic [7:0]        wdata,
   output logic [7:0]        rdata
);

   logic [7:0] mem_array [MEM_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_array[addr] <= wdata;
      end
      rdata_ff <= mem_array[addr];
   end

   assign rdata = rdata_ff;

endmodule

### design/svm_alu.sv
// Shared arithmetic unit: registered logic, shift, extend, add and multiply ops,
// radix-2 restoring divider for the divide and modulo ops. Depends on svm_pkg.
module svm_alu import svm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type alu_req,
   input  logic [31:0] opa,
   input  logic [31:0] opb,
   output logic        alu_done,
   output logic [31:0] alu_result
);

   typedef enum logic [1:0] {A_IDLE, A_DIV, A_FIX} alu_state_type;

   alu_state_type state_ff, state_in;
   logic          done_ff, done_in;
   logic [31:0]   res_ff, res_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   quo_ff, quo_in;
   logic [31:0]   dvs_ff, dvs_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [5:0]    op_ff, op_in;
   logic          na_ff, na_in;
   logic          nb_ff, nb_in;

   logic [4:0]    sh;
   logic [63:0]   prod;
   logic [32:0]   rem_sh;
   logic [32:0]   diff;
   logic          sgn_div;

   assign sh      = opb[4:0];
   assign prod    = opa * opb;
   assign rem_sh  = {rem_ff, quo_ff[31]};
   assign diff    = rem_sh - {1'b0, dvs_ff};
   assign sgn_div = (alu_req.op == OP_DIVL) || (alu_req.op == OP_MODL);

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      na_in    = na_ff;
      nb_in    = nb_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (alu_req.start) begin
               op_in = alu_req.op;
               if (alu_req.op == OP_DIVU || alu_req.op == OP_MODU || sgn_div) begin
                  na_in    = sgn_div & opa[31];
                  nb_in    = sgn_div & opb[31];
                  quo_in   = (sgn_div && opa[31]) ? 32'd0 - opa : opa;
                  dvs_in   = (sgn_div && opb[31]) ? 32'd0 - opb : opb;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = A_DIV;
               end else begin
                  done_in = 1'b1;
                  unique case (alu_req.op)
                     OP_SEX8:  res_in = {{24{opa[7]}}, opa[7:0]};
                     OP_SEX16: res_in = {{16{opa[15]}}, opa[15:0]};
                     OP_ZHI24: res_in = opa & 32'h0000_00FF;
                     OP_ZHI16: res_in = opa & 32'h0000_FFFF;
                     OP_NEGL:  res_in = 32'd0 - opa;
                     OP_BSL:   res_in = opa << sh;
                     OP_BSRI:  res_in = $unsigned($signed(opa) >>> sh);
                     OP_BSRU:  res_in = opa >> sh;
                     OP_BNOT:  res_in = ~opa;
                     OP_BAND:  res_in = opa & opb;
                     OP_BOR:   res_in = opa | opb;
                     OP_BXOR:  res_in = opa ^ opb;
                     OP_MULU, OP_MULL: res_in = prod[31:0];
                     OP_ADDL:  res_in = opa + opb;
                     OP_SUBL:  res_in = opa - opb;
                     default:  res_in = '0;
                  endcase
               end
            end
         end
         A_DIV: begin
            if (!diff[32]) begin
               rem_in = diff[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh[31:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            done_in  = 1'b1;
            state_in = A_IDLE;
            unique case (op_ff)
               OP_DIVU: res_in = quo_ff;
               OP_MODU: res_in = rem_ff;
               OP_DIVL: res_in = (na_ff != nb_ff) ? 32'd0 - quo_ff : quo_ff;
               default: res_in = na_ff ? 32'd0 - rem_ff : rem_ff;
            endcase
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      res_ff <= res_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      na_ff  <= na_in;
      nb_ff  <= nb_in;
   end

   assign alu_done   = done_ff;
   assign alu_result = res_ff;

endmodule

### design/stack_vm_instruction_executor_unit.sv
// Top level of the stack VM instruction executor: sequencer, byte memory, ALU.
// Depends on svm_pkg, svm_mem and svm_alu.
// One item at a time; the byte memory has one port and moves one byte a cycle,
// so timing follows the byte accesses. An execute item fetches three operand
// words, then writes its result, if the op has one. LOAD adds a word read, CALL
// two word writes and a word read, ENDSUB an 8-byte read; divide and modulo
// wait on the shared divider; COPY reads and then writes each byte moved. Host
// byte writes and reads access one byte. req_stall is high while busy; a
// finished result sits in the output register while the next item is taken.
module stack_vm_instruction_executor_unit import svm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_HRD, S_RD, S_WR, S_LATCH, S_EXEC, S_LOADW, S_ALU,
      S_CALL2, S_CALL3, S_CALL4, S_END2, S_CPR, S_CPW, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   state_type         after_ff, after_in;
   req_type           item_ff, item_in;
   rsp_type           res_ff, res_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   logic [16:0]       sp_ff, sp_in;
   logic [16:0]       cap_ff, cap_in;
   logic [16:0]       icnt_ff, icnt_in;
   logic [15:0]       reqblk_ff, reqblk_in;
   logic              expsub_ff, expsub_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [3:0]        len_ff, len_in;
   logic [MEM_AW-1:0] base_ff, base_in;
   logic [31:0]       wval_ff, wval_in;
   logic [95:0]       buf_ff, buf_in;
   logic [31:0]       a_ff, a_in;
   logic [31:0]       b_ff, b_in;
   logic [31:0]       c_ff, c_in;
   logic [MEM_AW-1:0] cp_src_ff, cp_src_in;
   logic [MEM_AW-1:0] cp_dst_ff, cp_dst_in;
   logic [16:0]       cp_left_ff, cp_left_in;
   logic              cp_fwd_ff, cp_fwd_in;

   logic [MEM_AW-1:0] mem_a;
   logic              mem_we;
   logic [7:0]        mem_wd;
   logic [7:0]        mem_rd;
   alu_req_type       alu_req;
   logic              alu_done;
   logic [31:0]       alu_result;

   logic [5:0]        op;
   logic [31:0]       arg;
   logic [31:0]       top32;
   logic [MEM_AW-1:0] sa_top;
   logic [31:0]       cap32;
   logic [31:0]       lim32;
   logic [32:0]       spsum33;
   logic [32:0]       so33;
   logic [32:0]       src33;
   logic [32:0]       dst33;
   logic              sgn_cmp;
   logic [31:0]       cx;
   logic [31:0]       cy;
   logic              take;
   logic [7:0]        wbyte;
   logic [3:0]        nbytes;

   svm_mem u_mem (
      .clock (clock),
      .addr  (mem_a),
      .we    (mem_we),
      .wdata (mem_wd),
      .rdata (mem_rd)
   );

   svm_alu u_alu (
      .clock      (clock),
      .reset      (reset),
      .alu_req    (alu_req),
      .opa        (a_ff),
      .opb        (b_ff),
      .alu_done   (alu_done),
      .alu_result (alu_result)
   );

   assign op      = item_ff.opcode;
   assign arg     = item_ff.argument;
   assign top32   = {16'd0, item_ff.stack_offset} - 32'd4;
   assign sa_top  = stk_addr(sp_ff, top32);
   assign cap32   = {15'd0, cap_ff};
   assign lim32   = ({15'd0, icnt_ff} < MAX_INSTR) ? {15'd0, icnt_ff} : MAX_INSTR;
   assign spsum33 = {16'd0, sp_ff} + {1'b0, arg};
   assign so33    = {16'd0, sp_ff} + {1'b0, buf_ff[95:64]};
   assign src33   = {1'b0, c_ff} + {1'b0, arg};
   assign dst33   = {1'b0, b_ff} + {1'b0, arg};
   assign sgn_cmp = (op >= OP_BGEU) && !op[0];
   assign cx      = sgn_cmp ? (b_ff ^ 32'h8000_0000) : b_ff;
   assign cy      = sgn_cmp ? (c_ff ^ 32'h8000_0000) : c_ff;

   always_comb begin
      unique case (op)
         OP_BEQ:            take = (cx == cy);
         OP_BNE:            take = (cx != cy);
         OP_BGEU, OP_BGEL:  take = (cx >= cy);
         OP_BGTU, OP_BGTL:  take = (cx > cy);
         OP_BLEU, OP_BLEL:  take = (cx <= cy);
         default:           take = (cx < cy);
      endcase
   end

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    wbyte = wval_ff[7:0];
         2'd1:    wbyte = wval_ff[15:8];
         2'd2:    wbyte = wval_ff[23:16];
         default: wbyte = wval_ff[31:24];
      endcase
   end

   always_comb begin
      unique case (op)
         OP_STORE1, OP_LOAD1, OP_DROP8:  nbytes = 4'd1;
         OP_STORE2, OP_LOAD2, OP_DROP16: nbytes = 4'd2;
         default:                        nbytes = 4'd4;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      sp_in        = sp_ff;
      cap_in       = cap_ff;
      icnt_in      = icnt_ff;
      reqblk_in    = reqblk_ff;
      expsub_in    = expsub_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      base_in      = base_ff;
      wval_in      = wval_ff;
      buf_in       = buf_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      cp_src_in    = cp_src_ff;
      cp_dst_in    = cp_dst_ff;
      cp_left_in   = cp_left_ff;
      cp_fwd_in    = cp_fwd_ff;
      mem_a        = base_ff + MEM_AW'(cnt_ff);
      mem_we       = 1'b0;
      mem_wd       = wbyte;
      alu_req      = '0;
      alu_req.op   = op;

      if (csr_write) begin
         unique case (csr_index)
            CSR_CAP:    cap_in  = csr_wdata;
            CSR_ICOUNT: icnt_in = csr_wdata;
            CSR_SSTART: sp_in   = {1'b0, csr_wdata[15:0]};
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_in   = '0;
            state_in = S_DONE;
            cnt_in   = '0;
            if (item_ff.mode == MODE_HWR) begin
               mem_a  = mem_addr({16'd0, item_ff.host_address});
               mem_we = 1'b1;
               mem_wd = item_ff.host_data;
            end else if (item_ff.mode == MODE_HRD) begin
               mem_a    = mem_addr({16'd0, item_ff.host_address});
               state_in = S_HRD;
            end else if (item_ff.mode == MODE_EXEC) begin
               expsub_in         = 1'b0;
               reqblk_in         = '0;
               res_in.next_index = item_ff.instr_index + 16'd1;
               if (expsub_ff && op != OP_BEGINSUB) begin
                  res_in.status     = ST_NOTSUB;
                  res_in.next_index = item_ff.instr_index;
               end else if (reqblk_ff != '0 && item_ff.block_id != reqblk_ff) begin
                  res_in.status = ST_ZONE;
               end else if (item_ff.instr_index == '0) begin
                  res_in.status = ST_NULL;
               end else if (op > OP_DROP16) begin
                  res_in.status     = ST_UNSUP;
                  res_in.next_index = item_ff.instr_index;
               end else begin
                  base_in  = sa_top;
                  len_in   = 4'd12;
                  after_in = S_LATCH;
                  state_in = S_RD;
               end
            end
         end
         S_HRD: begin
            res_in.read_data = mem_rd;
            state_in         = S_DONE;
         end
         S_RD: begin
            if (cnt_ff != '0) begin
               buf_in = {mem_rd, buf_ff[95:8]};
            end
            if (cnt_ff == len_ff) begin
               state_in = after_ff;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_WR: begin
            mem_we = 1'b1;
            if (cnt_ff == len_ff - 4'd1) begin
               state_in = after_ff;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_LATCH: begin
            a_in     = buf_ff[31:0];
            b_in     = buf_ff[63:32];
            c_in     = buf_ff[95:64];
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            cnt_in   = '0;
            after_in = S_DONE;
            len_in   = nbytes;
            base_in  = sa_top;
            unique case (op)
               OP_STORE1, OP_STORE2, OP_STORE4: begin
                  if (b_ff == '0) begin
                     res_in.status = ST_NULL;
                  end else if (b_ff >= cap32) begin
                     res_in.status = ST_ACCESS;
                  end else begin
                     base_in  = mem_addr(b_ff);
                     wval_in  = c_ff;
                     state_in = S_WR;
                  end
               end
               OP_LOAD1, OP_LOAD2, OP_LOAD4: begin
                  if (a_ff == '0) begin
                     res_in.status = ST_NULL;
                  end else if (a_ff >= cap32) begin
                     res_in.status = ST_ACCESS;
                  end else begin
                     base_in  = mem_addr(a_ff);
                     len_in   = 4'd4;
                     after_in = S_LOADW;
                     state_in = S_RD;
                  end
               end
               OP_SEX8, OP_SEX16, OP_ZHI24, OP_ZHI16, OP_NEGL, OP_BSL, OP_BSRI,
               OP_BSRU, OP_BNOT, OP_BAND, OP_BOR, OP_BXOR, OP_MULU, OP_ADDL,
               OP_SUBL, OP_MULL: begin
                  alu_req.start = 1'b1;
                  state_in      = S_ALU;
               end
               OP_DIVU, OP_MODU, OP_DIVL, OP_MODL: begin
                  if (b_ff == '0) begin
                     res_in.status = ST_DIVZERO;
                  end else begin
                     alu_req.start = 1'b1;
                     state_in      = S_ALU;
                  end
               end
               OP_CALL: begin
                  base_in  = stk_addr(sp_ff, 32'd0);
                  wval_in  = {16'd0, item_ff.instr_index} + 32'd1;
                  after_in = S_CALL2;
                  state_in = S_WR;
               end
               OP_JUMP: begin
                  if (b_ff >= lim32) begin
                     res_in.status = ST_CODE;
                  end else begin
                     res_in.next_index = b_ff[15:0];
                     reqblk_in         = item_ff.block_id;
                  end
               end
               OP_DISCARD: ;
               OP_SKIPNEXT: res_in.next_index = item_ff.instr_index + 16'd2;
               OP_ADDR_SPR, OP_ADDR_ARG: begin
                  wval_in  = {15'd0, sp_ff} + arg;
                  state_in = S_WR;
               end
               OP_BEGINSUB: begin
                  if (arg > {15'd0, sp_ff}) begin
                     res_in.status = ST_OVFL;
                  end else begin
                     sp_in = sp_ff - arg[16:0];
                  end
               end
               OP_ENDSUB: begin
                  sp_in    = spsum33[16:0];
                  base_in  = stk_addr(spsum33[16:0], 32'd0);
                  len_in   = 4'd8;
                  after_in = S_END2;
                  state_in = S_RD;
               end
               OP_COPY: begin
                  if (c_ff == '0 || c_ff >= cap32 || src33 > {1'b0, cap32} ||
                      b_ff == '0 || b_ff >= cap32 || dst33 > {1'b0, cap32}) begin
                     res_in.status = ST_NULL;
                  end else if (arg != '0) begin
                     cp_fwd_in  = (b_ff < c_ff);
                     cp_left_in = arg[16:0];
                     if (b_ff < c_ff) begin
                        cp_src_in = mem_addr(c_ff);
                        cp_dst_in = mem_addr(b_ff);
                     end else begin
                        cp_src_in = mem_addr(src33[31:0] - 32'd1);
                        cp_dst_in = mem_addr(dst33[31:0] - 32'd1);
                     end
                     state_in = S_CPR;
                  end
               end
               OP_BEQ, OP_BNE, OP_BGEU, OP_BGEL, OP_BGTU, OP_BGTL, OP_BLEU,
               OP_BLEL, OP_BLTU, OP_BLTL: begin
                  if (take) begin
                     res_in.next_index = arg[15:0];
                     reqblk_in         = item_ff.block_id;
                  end
               end
               OP_IMMED: begin
                  wval_in  = arg;
                  state_in = S_WR;
               end
               OP_STSPR4, OP_DROP8, OP_DROP16: begin
                  if (spsum33 >= {1'b0, cap32}) begin
                     res_in.status = ST_ACCESS;
                  end else begin
                     base_in  = stk_addr(sp_ff, arg);
                     wval_in  = b_ff;
                     state_in = S_WR;
                  end
               end
               default: res_in.status = ST_UNSUP;
            endcase
         end
         S_LOADW: begin
            base_in  = sa_top;
            wval_in  = buf_ff[95:64];
            len_in   = nbytes;
            cnt_in   = '0;
            after_in = S_DONE;
            state_in = S_WR;
         end
         S_ALU: begin
            if (alu_done) begin
               base_in  = sa_top;
               wval_in  = alu_result;
               len_in   = 4'd4;
               cnt_in   = '0;
               after_in = S_DONE;
               state_in = S_WR;
            end
         end
         S_CALL2: begin
            base_in  = stk_addr(sp_ff, 32'd4);
            wval_in  = top32;
            cnt_in   = '0;
            after_in = S_CALL3;
            state_in = S_WR;
         end
         S_CALL3: begin
            base_in  = sa_top;
            len_in   = 4'd4;
            cnt_in   = '0;
            after_in = S_CALL4;
            state_in = S_RD;
         end
         S_CALL4: begin
            state_in = S_DONE;
            if (buf_ff[95:64] == '0) begin
               res_in.status = ST_NULL;
            end else if (buf_ff[95:64] >= lim32) begin
               res_in.status = ST_CODE;
            end else begin
               res_in.next_index = buf_ff[79:64];
               expsub_in         = 1'b1;
            end
         end
         S_END2: begin
            state_in = S_DONE;
            if (buf_ff[63:32] == '0) begin
               res_in.status       = ST_EXITED;
               res_in.return_value = b_ff;
            end else if (buf_ff[65:64] != 2'd0) begin
               res_in.status = ST_ALIGN;
            end else if (so33 >= {1'b0, cap32}) begin
               res_in.status = ST_ACCESS;
            end else begin
               res_in.next_index = buf_ff[47:32];
               base_in           = stk_addr(sp_ff, buf_ff[95:64]);
               wval_in           = b_ff;
               len_in            = 4'd4;
               cnt_in            = '0;
               after_in          = S_DONE;
               state_in          = S_WR;
            end
         end
         S_CPR: begin
            mem_a    = cp_src_ff;
            state_in = S_CPW;
         end
         S_CPW: begin
            mem_a      = cp_dst_ff;
            mem_we     = 1'b1;
            mem_wd     = mem_rd;
            cp_left_in = cp_left_ff - 17'd1;
            if (cp_fwd_ff) begin
               cp_src_in = cp_src_ff + MEM_AW'(1);
               cp_dst_in = cp_dst_ff + MEM_AW'(1);
            end else begin
               cp_src_in = cp_src_ff - MEM_AW'(1);
               cp_dst_in = cp_dst_ff - MEM_AW'(1);
            end
            state_in = (cp_left_ff == 17'd1) ? S_DONE : S_CPR;
         end
         S_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         after_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         sp_ff        <= '0;
         cap_ff       <= 17'h1_0000;
         icnt_ff      <= '0;
         reqblk_ff    <= '0;
         expsub_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         out_valid_ff <= out_valid_in;
         sp_ff        <= sp_in;
         cap_ff       <= cap_in;
         icnt_ff      <= icnt_in;
         reqblk_ff    <= reqblk_in;
         expsub_ff    <= expsub_in;
      end
      item_ff    <= item_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
      cnt_ff     <= cnt_in;
      len_ff     <= len_in;
      base_ff    <= base_in;
      wval_ff    <= wval_in;
      buf_ff     <= buf_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      cp_src_ff  <= cp_src_in;
      cp_dst_ff  <= cp_dst_in;
      cp_left_ff <= cp_left_in;
      cp_fwd_ff  <= cp_fwd_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
